FILE: design/zlhnl_pkg.sv
// package for the zip local header name lister: payload types and header constants
package zlhnl_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 5;
  localparam int unsigned LenW   = 16;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned SkipW  = 34;

  localparam logic [PosW-1:0] HdrFlags   = 5'd6;
  localparam logic [PosW-1:0] HdrSize0   = 5'd18;
  localparam logic [PosW-1:0] HdrSize1   = 5'd19;
  localparam logic [PosW-1:0] HdrSize2   = 5'd20;
  localparam logic [PosW-1:0] HdrSize3   = 5'd21;
  localparam logic [PosW-1:0] HdrNameLo  = 5'd26;
  localparam logic [PosW-1:0] HdrNameHi  = 5'd27;
  localparam logic [PosW-1:0] HdrExtraLo = 5'd28;
  localparam logic [PosW-1:0] HdrExtraHi = 5'd29;
  localparam logic [PosW-1:0] BodyPos    = 5'd30;

  localparam logic [ByteW-1:0] StopMarker = 8'd24;
  localparam int unsigned      EncBit     = 0;
  localparam int unsigned      DescBit    = 3;

  localparam logic [ByteW-1:0] EncSkipReset  = 8'd8;
  localparam logic [ByteW-1:0] DescSkipReset = 8'd18;

  localparam logic CfgEncSkip  = 1'b0;
  localparam logic CfgDescSkip = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_input;
  } in_beat_t;

  typedef struct packed {
    logic             name_valid;
    logic [ByteW-1:0] name_byte;
    logic             first_of_name;
    logic             last_of_name;
    logic             listing_done;
  } out_beat_t;

endpackage

FILE: design/zip_local_header_name_lister.sv
// zip local header walker: passes out file-name bytes of each local header
// output: a result beat is registered and offered in the cycle after the byte that causes it
// throughput: one byte per cycle; the single output register is refilled
//   in the cycle it drains, so input stalls only while a result waits
// reset: asynchronous, clears the header walk and restores skip registers 8 and 18
module zip_local_header_name_lister
  import zlhnl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_beat_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_beat_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [ByteW-1:0] enc_skip_q, desc_skip_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             enc_q, enc_d, desc_q, desc_d;
  logic [SizeW-1:0] csize_q, csize_d;
  logic [LenW-1:0]  name_len_q, name_len_d;
  logic [LenW-1:0]  ext_len_q, ext_len_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [SkipW-1:0] skip_q, skip_d, skip_sum;
  logic             stopped_q, stopped_d;
  logic             stop_hit, have_name, first_b, last_b;
  logic             res_valid;
  out_beat_t        res;
  logic             out_valid_q;
  out_beat_t        out_q;
  logic             in_fire;
  logic [ByteW-1:0] b;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign b           = in_data_i.data_byte;

  always_comb begin
    pos_d      = pos_q;
    enc_d      = enc_q;
    desc_d     = desc_q;
    csize_d    = csize_q;
    name_len_d = name_len_q;
    ext_len_d  = ext_len_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    stopped_d  = stopped_q;
    skip_sum   = '0;
    stop_hit   = 1'b0;
    have_name  = 1'b0;
    first_b    = 1'b0;
    last_b     = 1'b0;
    res_valid  = 1'b0;
    res        = '0;
    if (!stopped_q) begin
      if (pos_q != BodyPos) begin
        case (pos_q)
          HdrFlags: begin
            enc_d  = b[EncBit];
            desc_d = b[DescBit];
          end
          HdrSize0:   csize_d[7:0]      = b;
          HdrSize1:   csize_d[15:8]     = b;
          HdrSize2:   csize_d[23:16]    = b;
          HdrSize3:   csize_d[31:24]    = b;
          HdrNameLo:  name_len_d[7:0]   = b;
          HdrNameHi:  name_len_d[15:8]  = b;
          HdrExtraLo: ext_len_d[7:0]    = b;
          HdrExtraHi: ext_len_d[15:8]   = b;
          default: ;
        endcase
        if (pos_q == HdrExtraHi) begin
          skip_sum = SkipW'(ext_len_d) + SkipW'(csize_q)
                   + (enc_q  ? SkipW'(enc_skip_q)  : '0)
                   + (desc_q ? SkipW'(desc_skip_q) : '0);
          skip_d = skip_sum;
          cnt_d  = '0;
          pos_d  = (name_len_q == '0 && skip_sum == '0) ? '0 : BodyPos;
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end else if (cnt_q < name_len_q) begin
        if (cnt_q == '0 && b == StopMarker) begin
          stop_hit  = 1'b1;
          stopped_d = 1'b1;
          res_valid = 1'b1;
          res.listing_done = 1'b1;
        end else begin
          have_name = 1'b1;
          first_b   = (cnt_q == '0);
          last_b    = ({1'b0, cnt_q} + 17'd1) == {1'b0, name_len_q};
          cnt_d     = cnt_q + LenW'(1);
          if (cnt_d >= name_len_q && skip_q == '0) begin
            pos_d = '0;
            cnt_d = '0;
          end
        end
      end else begin
        if (skip_q != '0) begin
          skip_d = skip_q - SkipW'(1);
        end
        if (skip_d == '0) begin
          pos_d = '0;
          cnt_d = '0;
        end
      end
      if (!stop_hit) begin
        if (in_data_i.end_of_input || have_name) begin
          res_valid         = 1'b1;
          res.name_valid    = have_name;
          res.name_byte     = have_name ? b : '0;
          res.first_of_name = have_name && first_b;
          res.last_of_name  = have_name && last_b;
          res.listing_done  = in_data_i.end_of_input;
        end
        if (in_data_i.end_of_input) begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_skip_q  <= EncSkipReset;
      desc_skip_q <= DescSkipReset;
      pos_q       <= '0;
      enc_q       <= 1'b0;
      desc_q      <= 1'b0;
      csize_q     <= '0;
      name_len_q  <= '0;
      ext_len_q   <= '0;
      cnt_q       <= '0;
      skip_q      <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgEncSkip:  enc_skip_q  <= cfg_data_i;
          CfgDescSkip: desc_skip_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        pos_q      <= pos_d;
        enc_q      <= enc_d;
        desc_q     <= desc_d;
        csize_q    <= csize_d;
        name_len_q <= name_len_d;
        ext_len_q  <= ext_len_d;
        cnt_q      <= cnt_d;
        skip_q     <= skip_d;
        stopped_q  <= stopped_d;
      end
      if (in_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

endmodule

FILE: sim/tb_zip_local_header_name_lister.sv
// testbench for the zip local header name lister: archive stimulus, name beat prediction, checks
`timescale 1ns / 100ps

module tb_zip_local_header_name_lister;
  import zlhnl_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_beat_t   in_data_i   = '0;
  logic       out_valid_o;
  wire        out_ready_i;
  out_beat_t  out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_index_i = CfgEncSkip;
  logic [7:0] cfg_data_i  = '0;

  zip_local_header_name_lister dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // header walk mirror
  logic [ByteW-1:0] enc_skip  = EncSkipReset;
  logic [ByteW-1:0] desc_skip = DescSkipReset;
  logic [PosW-1:0]  hdr_pos   = '0;
  logic             enc_flag  = 1'b0;
  logic             desc_flag = 1'b0;
  logic [SizeW-1:0] comp_size = '0;
  logic [LenW-1:0]  name_len  = '0;
  logic [LenW-1:0]  extra_len = '0;
  logic [LenW-1:0]  name_cnt  = '0;
  logic [SkipW-1:0] skip_left = '0;
  logic             listing_stopped = 1'b0;

  in_beat_t  archive_bytes[$];
  out_beat_t name_beats_due[$];

  int   bytes_taken = 0;
  int   bytes_queued = 0;
  int   beats_seen = 0;
  int   errors = 0;
  int   reported = 0;
  int   settings_used = 1;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   hold_cnt = 0;
  int   hold_clock = 0;
  bit   hold_used = 1'b0;
  bit   burst = 1'b0;
  logic rx_ready = 1'b1;
  logic      nxt_valid;
  in_beat_t  nxt_data;
  out_beat_t due;
  string     ending_kind;

  assign out_ready_i = rx_ready && (hold_cnt == 0);

  task automatic check_next_header();
    if (name_cnt >= name_len && skip_left == '0) begin
      hdr_pos  = '0;
      name_cnt = '0;
    end
  endtask

  task automatic walk_header_byte(input in_beat_t beat);
    out_beat_t  res;
    logic       have_name;
    logic       first;
    logic       last;
    logic [7:0] b;
    b         = beat.data_byte;
    have_name = 1'b0;
    first     = 1'b0;
    last      = 1'b0;
    res       = '0;
    if (listing_stopped) return;
    if (hdr_pos < BodyPos) begin
      case (hdr_pos)
        HdrFlags: begin
          enc_flag  = b[EncBit];
          desc_flag = b[DescBit];
        end
        HdrSize0:   comp_size[7:0]   = b;
        HdrSize1:   comp_size[15:8]  = b;
        HdrSize2:   comp_size[23:16] = b;
        HdrSize3:   comp_size[31:24] = b;
        HdrNameLo:  name_len[7:0]    = b;
        HdrNameHi:  name_len[15:8]   = b;
        HdrExtraLo: extra_len[7:0]   = b;
        HdrExtraHi: extra_len[15:8]  = b;
        default: ;
      endcase
      if (hdr_pos == HdrExtraHi) begin
        skip_left = SkipW'(extra_len) + SkipW'(comp_size)
                  + (enc_flag ? SkipW'(enc_skip) : '0)
                  + (desc_flag ? SkipW'(desc_skip) : '0);
        name_cnt  = '0;
        hdr_pos   = BodyPos;
        check_next_header();
      end else begin
        hdr_pos = hdr_pos + 1'b1;
      end
    end else if (name_cnt < name_len) begin
      if (name_cnt == '0 && b == StopMarker) begin
        listing_stopped  = 1'b1;
        res.listing_done = 1'b1;
        name_beats_due.push_back(res);
        return;
      end
      have_name = 1'b1;
      first     = (name_cnt == '0);
      last      = (int'(name_cnt) + 1 == int'(name_len));
      name_cnt  = name_cnt + 1'b1;
      check_next_header();
    end else begin
      if (skip_left != '0) skip_left = skip_left - 1'b1;
      check_next_header();
    end
    res.name_valid    = have_name;
    res.name_byte     = have_name ? b : '0;
    res.first_of_name = have_name && first;
    res.last_of_name  = have_name && last;
    res.listing_done  = beat.end_of_input;
    if (beat.end_of_input) listing_stopped = 1'b1;
    if (have_name || beat.end_of_input) name_beats_due.push_back(res);
  endtask

  // one local entry: header, name, then extra field, optional skips and data
  task automatic add_entry(input logic [7:0] flags, input int name_n, input int size,
                           input int extra, input int first_byte, input int cut_at);
    logic [7:0] bytes[$];
    logic [7:0] nb;
    int         skip_n;
    in_beat_t   beat;
    for (int i = 0; i < 30; i++) bytes.push_back(8'($urandom_range(0, 255)));
    bytes[HdrFlags]   = flags;
    bytes[HdrSize0]   = size[7:0];
    bytes[HdrSize1]   = size[15:8];
    bytes[HdrSize2]   = size[23:16];
    bytes[HdrSize3]   = size[31:24];
    bytes[HdrNameLo]  = name_n[7:0];
    bytes[HdrNameHi]  = name_n[15:8];
    bytes[HdrExtraLo] = extra[7:0];
    bytes[HdrExtraHi] = extra[15:8];
    for (int i = 0; i < name_n; i++) begin
      nb = 8'($urandom_range(0, 255));
      if (i == 0) begin
        if (first_byte >= 0) nb = first_byte[7:0];
        else if (nb == StopMarker) nb = ~nb;
      end
      bytes.push_back(nb);
    end
    skip_n = extra + size + (flags[EncBit] ? int'(enc_skip) : 0)
           + (flags[DescBit] ? int'(desc_skip) : 0);
    for (int i = 0; i < skip_n; i++) bytes.push_back(8'($urandom_range(0, 255)));
    foreach (bytes[i]) begin
      beat.data_byte    = bytes[i];
      beat.end_of_input = (i == cut_at);
      archive_bytes.push_back(beat);
      bytes_queued++;
      if (i == cut_at) break;
    end
  endtask

  task automatic add_random_entry();
    logic [7:0] flags;
    int         nlen;
    int         size;
    int         extra;
    flags = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       nlen = 0;
      1:       nlen = $urandom_range(13, 40);
      default: nlen = $urandom_range(1, 12);
    endcase
    size  = $urandom_range(0, 20);
    extra = $urandom_range(0, 8);
    if ($urandom_range(0, 7) == 0) begin
      flags[EncBit]  = 1'b0;
      flags[DescBit] = 1'b0;
      size           = 0;
      extra          = 0;
    end
    add_entry(flags, nlen, size, extra, -1, -1);
  endtask

  task automatic write_skip(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CfgEncSkip) enc_skip = val;
    else desc_skip = val;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((archive_bytes.size() != 0 || in_valid_i || name_beats_due.size() != 0)
           && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    nxt_valid = in_valid_i;
    nxt_data  = in_data_i;
    if (in_valid_i && in_ready_o) begin
      walk_header_byte(in_data_i);
      bytes_taken++;
      nxt_valid = 1'b0;
    end
    if (!nxt_valid) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (archive_bytes.size() != 0) begin
        nxt_data  = archive_bytes.pop_front();
        nxt_valid = 1'b1;
        tx_gap    = burst ? 0 : $urandom_range(0, 15);
      end
    end
    in_valid_i <= nxt_valid;
    in_data_i  <= nxt_data;
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      beats_seen++;
      if (name_beats_due.size() == 0) begin
        errors++;
        if (reported < 10)
          $display("unexpected beat: valid=%0b byte=%02h first=%0b last=%0b done=%0b",
                   out_data_o.name_valid, out_data_o.name_byte, out_data_o.first_of_name,
                   out_data_o.last_of_name, out_data_o.listing_done);
        reported++;
      end else begin
        due = name_beats_due.pop_front();
        if (out_data_o.name_valid !== due.name_valid ||
            out_data_o.name_byte !== due.name_byte ||
            out_data_o.first_of_name !== due.first_of_name ||
            out_data_o.last_of_name !== due.last_of_name ||
            out_data_o.listing_done !== due.listing_done) begin
          errors++;
          if (reported < 10)
            $display({"mismatch at beat %0d: exp valid=%0b byte=%02h first=%0b last=%0b",
                      " done=%0b, got valid=%0b byte=%02h first=%0b last=%0b done=%0b"},
                     beats_seen, due.name_valid, due.name_byte, due.first_of_name,
                     due.last_of_name, due.listing_done, out_data_o.name_valid,
                     out_data_o.name_byte, out_data_o.first_of_name,
                     out_data_o.last_of_name, out_data_o.listing_done);
          reported++;
        end
      end
      rx_wait = burst ? 0 : $urandom_range(0, 15);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    rx_ready <= (rx_wait == 0);
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) hold_clock <= hold_clock + 1;
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_used && out_valid_o && hold_clock > 300) begin
      hold_cnt  <= 300;
      hold_used <= 1'b1;
    end
  end

  initial begin
    logic [7:0] enc_set[8];
    logic [7:0] desc_set[8];
    int         phase_start;
    in_beat_t   tail_beat;
    enc_set  = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    desc_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
    for (int i = 4; i < 8; i++) begin
      enc_set[i]  = 8'($urandom_range(0, 31));
      desc_set[i] = 8'($urandom_range(0, 31));
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed entries at reset skip values
    add_entry(8'h00, 1, 0, 0, -1, -1);
    add_entry(8'h00, 0, 0, 0, -1, -1);
    add_entry(8'h01, 3, 2, 1, -1, -1);
    add_entry(8'h08, 2, 0, 0, 255, -1);
    add_entry(8'hFF, 4, 1, 0, 0, -1);
    add_entry(8'hF6, 0, 5, 0, -1, -1);
    add_entry(8'h00, 256, 0, 0, -1, -1);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_skip(CfgEncSkip, enc_set[p]);
      write_skip(CfgDescSkip, desc_set[p]);
      settings_used++;
      burst       = (p % 3 == 2);
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < 40) add_random_entry();
      wait_drained();
    end

    burst = 1'b0;
    case ($urandom_range(0, 2))
      0: begin
        ending_kind = "stop marker";
        add_entry(8'($urandom_range(0, 255)), 5, 3, 2, StopMarker, -1);
      end
      1: begin
        ending_kind = "end of input inside a name";
        add_entry(8'($urandom_range(0, 255)), 6, 3, 2, -1, 32);
      end
      default: begin
        ending_kind = "end of input inside a header";
        add_entry(8'($urandom_range(0, 255)), 6, 3, 2, -1, $urandom_range(0, 29));
      end
    endcase
    // trailing bytes after the stop must be swallowed
    for (int i = 0; i < 16; i++) begin
      tail_beat.data_byte    = 8'($urandom_range(0, 255));
      tail_beat.end_of_input = 1'($urandom_range(0, 1));
      archive_bytes.push_back(tail_beat);
      bytes_queued++;
    end
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (name_beats_due.size() != 0) begin
      errors += name_beats_due.size();
      $display("%0d expected name beats never arrived", name_beats_due.size());
    end
    $display("covered %0d archive bytes and %0d result beats over %0d skip settings",
             bytes_taken, beats_seen, settings_used);
    $display("listing ended by %s, %0d mismatches", ending_kind, errors);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d name beats outstanding", name_beats_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
